// ===== rtl/core/hpe_pkg.sv =====
package hpe_pkg;

  localparam int DIMS                 = 3;
  localparam int NNEIGH               = 26;
  localparam int NSUB                 = (1 << DIMS) - 1;
  localparam int ATOM_W               = 16;
  localparam int POS_W                = 32;
  localparam int EXT_POS_W            = POS_W + 2;
  localparam int SKIN_W               = 31;
  localparam int NB_W                 = 5;
  localparam int SLOT_W               = 16;
  localparam int CFG_W                = 32;
  localparam int CFG_IDX_W            = 3;
  localparam int MAX_PER_NEIGHBOR_DEF = 65536;

  localparam logic [1:0] CODE_ITM = 2'd0;
  localparam logic [1:0] CODE_NLB = 2'd1;
  localparam logic [1:0] CODE_NUB = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SKIN    = 3'd6;

  localparam logic [NB_W-1:0] POW3 [DIMS] = '{5'd1, 5'd3, 5'd9};

  typedef logic [1:0] code_t;

  typedef struct packed {
    logic [DIMS-1:0][POS_W-1:0] lower;
    logic [DIMS-1:0][POS_W-1:0] upper;
    logic [SKIN_W-1:0]          skin;
  } cfg_t;

  typedef struct packed {
    code_t [DIMS-1:0]  code;
    logic [ATOM_W-1:0] atom_id;
    logic              first_atom;
  } cls_t;

  // base-3 index of the axis subset sel, minus one
  function automatic logic [NB_W-1:0] neighbor_of(logic [DIMS-1:0] sel,
                                                  code_t [DIMS-1:0] code);
    logic [NB_W-1:0] v;
    v = '0;
    for (int d = 0; d < DIMS; d++) begin
      if (sel[d]) begin
        v = v + NB_W'(code[d] * POW3[d]);
      end
    end
    return v - NB_W'(1);
  endfunction

endpackage

// ===== rtl/core/hpe_ifs.sv =====
interface hpe_atom_if import hpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ATOM_W-1:0] atom_id;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;
  logic              first_atom;

  modport source (output valid, atom_id, pos_x, pos_y, pos_z, first_atom, input ready);
  modport sink   (input valid, atom_id, pos_x, pos_y, pos_z, first_atom, output ready);
endinterface

interface hpe_result_if import hpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NB_W-1:0]   neighbor;
  logic [SLOT_W-1:0] slot;
  logic [ATOM_W-1:0] atom_out;
  logic              overflow;
  logic              last;

  modport source (output valid, neighbor, slot, atom_out, overflow, last, input ready);
  modport sink   (input valid, neighbor, slot, atom_out, overflow, last, output ready);
endinterface

// ===== rtl/core/halo_particle_export_router.sv =====
// Atoms pass the hpe_classify register, then the emitter's pending and code
// registers; results are registered. Throughput, while results.ready holds:
// one atom per cycle if each has at most one result; an atom with k results
// (k up to 7) gives one per cycle: one neighbor counter update per cycle.
// Reset: synchronous rst clears the bounds, skin and all neighbor counters.
module halo_particle_export_router import hpe_pkg::*; #(
  parameter int MAX_PER_NEIGHBOR = MAX_PER_NEIGHBOR_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  hpe_atom_if.sink             atoms,
  hpe_result_if.source         results
);

  cfg_t cfg;
  logic cls_valid;
  logic cls_ready;
  cls_t cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOWER_X: cfg.lower[0] <= cfg_data;
        REG_LOWER_Y: cfg.lower[1] <= cfg_data;
        REG_LOWER_Z: cfg.lower[2] <= cfg_data;
        REG_UPPER_X: cfg.upper[0] <= cfg_data;
        REG_UPPER_Y: cfg.upper[1] <= cfg_data;
        REG_UPPER_Z: cfg.upper[2] <= cfg_data;
        REG_SKIN:    cfg.skin     <= cfg_data[SKIN_W-1:0];
        default: ;
      endcase
    end
  end

  hpe_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .atoms     (atoms),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls       (cls)
  );

  hpe_emitter #(
    .MAX_PER_NEIGHBOR (MAX_PER_NEIGHBOR)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls       (cls),
    .results   (results)
  );

  a_ovf_slot: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.overflow |-> results.slot == '0)
    else $error("overflow result with nonzero slot");

  a_nb_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.neighbor < NB_W'(NNEIGH))
    else $error("neighbor index out of range");

  a_rst_out: assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/core/hpe_classify.sv =====
module hpe_classify import hpe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  hpe_atom_if.sink   atoms,
  output logic       cls_valid,
  input  logic       cls_ready,
  output cls_t       cls
);

  logic                       a_valid;
  logic [ATOM_W-1:0]          a_atom_id;
  logic [DIMS-1:0][POS_W-1:0] a_pos;
  logic                       a_first;

  logic [DIMS-1:0][EXT_POS_W-1:0] lo_thr;
  logic [DIMS-1:0][EXT_POS_W-1:0] hi_thr;
  logic [DIMS-1:0][EXT_POS_W-1:0] pos_ext;

  assign atoms.ready = !a_valid || cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (atoms.ready) begin
      a_valid <= atoms.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (atoms.valid && atoms.ready) begin
      a_atom_id <= atoms.atom_id;
      a_pos[0]  <= atoms.pos_x;
      a_pos[1]  <= atoms.pos_y;
      a_pos[2]  <= atoms.pos_z;
      a_first   <= atoms.first_atom;
    end
  end

  // 34-bit signed thresholds, exact
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      lo_thr[d]  = {{2{cfg.lower[d][POS_W-1]}}, cfg.lower[d]} + {3'b000, cfg.skin};
      hi_thr[d]  = {{2{cfg.upper[d][POS_W-1]}}, cfg.upper[d]} - {3'b000, cfg.skin};
      pos_ext[d] = {{2{a_pos[d][POS_W-1]}}, a_pos[d]};
    end
  end

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      priority if ($signed(pos_ext[d]) < $signed(lo_thr[d])) begin
        cls.code[d] = CODE_NLB;
      end else if ($signed(pos_ext[d]) > $signed(hi_thr[d])) begin
        cls.code[d] = CODE_NUB;
      end else begin
        cls.code[d] = CODE_ITM;
      end
    end
    cls.atom_id    = a_atom_id;
    cls.first_atom = a_first;
  end

  assign cls_valid = a_valid;

endmodule

// ===== rtl/core/hpe_emitter.sv =====
module hpe_emitter import hpe_pkg::*; #(
  parameter int MAX_PER_NEIGHBOR = MAX_PER_NEIGHBOR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cls_valid,
  output logic        cls_ready,
  input  cls_t        cls,
  hpe_result_if.source results
);

  localparam int CNT_W = $clog2(MAX_PER_NEIGHBOR + 1);
  localparam int EXT_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PER_NEIGHBOR);
  localparam logic [EXT_W-1:0] SLOT_SAT = EXT_W'((1 << SLOT_W) - 1);

  logic [NSUB-1:0]   pending;
  code_t [DIMS-1:0]  code;
  logic [ATOM_W-1:0] atom_id;
  logic [CNT_W-1:0]  send_counts [NNEIGH];

  logic [NSUB-1:0]   pick;
  logic [NSUB-1:0]   rest;
  logic [NSUB-1:0]   pending_next;
  logic [DIMS-1:0]   sel;
  logic [DIMS-1:0]   near;
  logic [NB_W-1:0]   nb;
  logic [CNT_W-1:0]  cnt;
  logic [EXT_W-1:0]  cnt_ext;
  logic              ovf;
  logic [SLOT_W-1:0] slot;
  logic              emit_fire;
  logic              load;

  // highest subset first gives descending neighbor index
  always_comb begin
    pick = '0;
    sel  = '0;
    for (int m = NSUB; m >= 1; m--) begin
      if (pending[m-1] && (pick == '0)) begin
        pick[m-1] = 1'b1;
        sel       = DIMS'(m);
      end
    end
  end

  assign rest      = pending & ~pick;
  assign nb        = neighbor_of(sel, code);
  assign cnt       = send_counts[nb];
  assign cnt_ext   = EXT_W'(cnt);
  assign ovf       = (cnt >= CNT_MAX);
  assign slot      = ovf ? '0 : ((cnt_ext > SLOT_SAT) ? '1 : cnt_ext[SLOT_W-1:0]);
  assign emit_fire = (pending != '0) && (!results.valid || results.ready);
  assign cls_ready = (pending == '0) || (emit_fire && (rest == '0));
  assign load      = cls_valid && cls_ready;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      near[d] = (cls.code[d] != CODE_ITM);
    end
    for (int m = 1; m <= NSUB; m++) begin
      pending_next[m-1] = ((DIMS'(m) & ~near) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= '0;
      results.valid <= 1'b0;
      for (int i = 0; i < NNEIGH; i++) begin
        send_counts[i] <= '0;
      end
    end else begin
      if (load) begin
        pending <= pending_next;
      end else if (emit_fire) begin
        pending <= rest;
      end
      if (emit_fire) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      // clear overrides the previous atom's final update
      if (load && cls.first_atom) begin
        for (int i = 0; i < NNEIGH; i++) begin
          send_counts[i] <= '0;
        end
      end else if (emit_fire && !ovf) begin
        send_counts[nb] <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code    <= cls.code;
      atom_id <= cls.atom_id;
    end
    if (emit_fire) begin
      results.neighbor <= nb;
      results.slot     <= slot;
      results.atom_out <= atom_id;
      results.overflow <= ovf;
      results.last     <= (rest == '0);
    end
  end

endmodule
